>>> hdl/page_frame_allocator_lru_evict_assert.svh
// Assertion macros for the page frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_LRU_EVICT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_LRU_EVICT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PFA_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PFA_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error(msg);
`endif

>>> hdl/pfa_pkg.sv
// Shared types and constants of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package pfa_pkg;
    localparam int PAGE_FRAMES_DEF = 1024;
    localparam int AGE_BITS_DEF    = 32;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_FREE = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic       CFG_FIRST = 1'b0;
    localparam logic       CFG_TOTAL = 1'b1;

    // Memory access request from the sequencer.
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic        wr_used;
        logic [10:0] wr_len;
    } mem_ctl_t;
endpackage
`default_nettype wire

>>> hdl/pfa_table.sv
// Page frame table memory: used mark, run length and age stamp per frame.
`timescale 1ns / 1ps
`default_nettype none
module pfa_table #(
    parameter int PAGE_FRAMES = pfa_pkg::PAGE_FRAMES_DEF,
    parameter int AGE_BITS    = pfa_pkg::AGE_BITS_DEF,
    localparam int AW = $clog2(PAGE_FRAMES)
) (
    input  wire logic                aclk,
    input  wire pfa_pkg::mem_ctl_t   ctl,
    input  wire logic [AW-1:0]       rd_addr,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic [AGE_BITS-1:0] wr_age,
    output logic                     rd_used,
    output logic [10:0]              rd_len,
    output logic [AGE_BITS-1:0]      rd_age
);
    logic [AGE_BITS+11:0] mem [PAGE_FRAMES];
    logic [AGE_BITS+11:0] rd_q;

    // Single write port, single registered read port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= {ctl.wr_used, ctl.wr_len, wr_age};
        end
        if (ctl.rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    assign rd_used = rd_q[AGE_BITS+11];
    assign rd_len  = rd_q[AGE_BITS+10:AGE_BITS];
    assign rd_age  = rd_q[AGE_BITS-1:0];
endmodule
`default_nettype wire

>>> hdl/pfa_ctrl.sv
// Sequencer: clearing pass, first-fit scan, oldest-run scan, run writes.
`timescale 1ns / 1ps
`default_nettype none
module pfa_ctrl #(
    parameter int PAGE_FRAMES = pfa_pkg::PAGE_FRAMES_DEF,
    parameter int AGE_BITS    = pfa_pkg::AGE_BITS_DEF,
    localparam int AW = $clog2(PAGE_FRAMES),
    localparam int CW = AW + 1
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic                req_op,
    input  wire logic [10:0]         req_count,
    input  wire logic [9:0]          req_index,
    input  wire logic [9:0]          first_page,
    input  wire logic [10:0]         total_pages,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic [1:0]               res_status,
    output logic [9:0]               res_start,
    output logic                     res_evicted,
    output logic [9:0]               res_ev_index,
    output logic [10:0]              res_ev_length,
    output pfa_pkg::mem_ctl_t        ctl,
    output logic [AW-1:0]            rd_addr,
    output logic [AW-1:0]            wr_addr,
    output logic [AGE_BITS-1:0]      wr_age,
    input  wire logic                rd_used,
    input  wire logic [10:0]         rd_len,
    input  wire logic [AGE_BITS-1:0] rd_age
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FREE  = 4'd2;
    localparam logic [3:0] S_FREEW = 4'd3;
    localparam logic [3:0] S_FIT   = 4'd4;
    localparam logic [3:0] S_OLD   = 4'd5;
    localparam logic [3:0] S_CLR   = 4'd6;
    localparam logic [3:0] S_ALLOC = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam logic [CW-1:0] FRAMES = CW'(PAGE_FRAMES);

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       ptr_reg, ptr_next;    // scan pointer, may reach FRAMES
    logic [CW-1:0]       lo_reg, lo_next, hi_reg, hi_next;
    logic                pend_reg, pend_next;  // read data valid for ptr_reg-1
    logic [10:0]         cnt_reg, cnt_next;
    logic [10:0]         n_reg, n_next;
    logic [10:0]         used_reg, used_next;
    logic [AGE_BITS-1:0] age_reg, age_next;
    logic                second_reg, second_next;
    logic                best_ok_reg, best_ok_next;
    logic [AW-1:0]       best_reg, best_next;
    logic [AGE_BITS-1:0] best_age_reg, best_age_next;
    logic [CW-1:0]       run_reg, run_next;   // remaining pages to clear or write
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       waddr_reg, waddr_next;
    logic                out_v_reg, out_v_next;
    logic [1:0]          st_reg, st_next;
    logic [9:0]          start_reg, start_next;
    logic                ev_reg, ev_next;
    logic [9:0]          evi_reg, evi_next;
    logic [10:0]         evl_reg, evl_next;
    logic                tgt_alloc_reg, tgt_alloc_next; // after a clear: fit scan

    logic [CW-1:0]       hi_eff, lo_ext, span, freec, raddr;
    logic [AW-1:0]       cur;          // address whose data is on rd_*
    logic [AGE_BITS-1:0] stamp;

    always_comb begin
        hi_eff = ({{(CW > 11 ? CW-11 : 0){1'b0}}, total_pages} < {1'b0, FRAMES})
               ? CW'(total_pages) : FRAMES;
        lo_ext = CW'(first_page);
        span   = (hi_eff > lo_ext) ? hi_eff - lo_ext : '0;
        freec  = (span > CW'(used_reg)) ? span - CW'(used_reg) : '0;
        stamp  = age_reg + AGE_BITS'(1);
        if (stamp == '0) begin
            stamp = AGE_BITS'(1);
        end
        cur = AW'(ptr_reg - CW'(1));
    end

    assign req_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign res_valid = out_v_reg;
    assign res_status = st_reg;
    assign res_start = start_reg;
    assign res_evicted = ev_reg;
    assign res_ev_index = evi_reg;
    assign res_ev_length = evl_reg;
    assign rd_addr = AW'(raddr);
    assign wr_addr = waddr_reg;

    // Advance the sequencer one memory access per cycle.
    always_comb begin
        state_next = state_reg; ptr_next = ptr_reg; lo_next = lo_reg; hi_next = hi_reg;
        pend_next = 1'b0; cnt_next = cnt_reg; n_next = n_reg; used_next = used_reg;
        age_next = age_reg; second_next = second_reg; best_ok_next = best_ok_reg;
        best_next = best_reg; best_age_next = best_age_reg; run_next = run_reg;
        pos_next = pos_reg; waddr_next = waddr_reg; out_v_next = out_v_reg;
        st_next = st_reg; start_next = start_reg; ev_next = ev_reg; evi_next = evi_reg;
        evl_next = evl_reg; tgt_alloc_next = tgt_alloc_reg;
        ctl = '0; raddr = ptr_reg; wr_age = '0;
        if (out_v_reg && res_ready) begin
            out_v_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR: begin
                ctl.wr_en = 1'b1;
                waddr_next = waddr_reg;
                if (waddr_reg == AW'(PAGE_FRAMES - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    waddr_next = waddr_reg + AW'(1);
                end
            end
            S_IDLE: begin
                if (req_valid && req_ready) begin
                    ev_next = 1'b0; evi_next = '0; evl_next = '0; start_next = '0;
                    st_next = pfa_pkg::ST_OK; n_next = req_count;
                    lo_next = lo_ext; hi_next = hi_eff; second_next = 1'b0;
                    tgt_alloc_next = 1'b0;
                    if (req_op == pfa_pkg::OP_FREE) begin
                        if (CW'(req_index) >= FRAMES) begin
                            st_next = pfa_pkg::ST_BAD_FREE; state_next = S_DONE;
                        end else begin
                            ctl.rd_en = 1'b1; raddr = CW'(req_index);
                            pos_next = AW'(req_index); state_next = S_FREE;
                        end
                    end else if (req_count == '0) begin
                        st_next = pfa_pkg::ST_BAD_SIZE; state_next = S_DONE;
                    end else if (freec >= CW'(req_count)) begin
                        ptr_next = lo_ext; cnt_next = '0; state_next = S_FIT;
                    end else begin
                        ptr_next = lo_ext; best_ok_next = 1'b0; state_next = S_OLD;
                    end
                end
            end
            S_FREE: state_next = S_FREEW;
            S_FREEW: begin
                if (!rd_used || rd_len == '0) begin
                    st_next = pfa_pkg::ST_BAD_FREE; state_next = S_DONE;
                end else begin
                    run_next = CW'(rd_len); waddr_next = pos_reg;
                    tgt_alloc_next = 1'b0; state_next = S_CLR;
                end
            end
            S_CLR: begin
                // Clear one page of the run per cycle, clipped at the table end.
                if (run_reg == '0) begin
                    if (tgt_alloc_reg) begin
                        ptr_next = lo_reg; cnt_next = '0; second_next = 1'b1;
                        state_next = S_FIT;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    ctl.wr_en = 1'b1;
                    ctl.rd_en = 1'b1; raddr = CW'(waddr_reg);
                    used_next = (used_reg != '0) ? used_reg - 11'd1 : '0;
                    run_next = run_reg - CW'(1);
                    if (waddr_reg == AW'(PAGE_FRAMES - 1)) begin
                        run_next = '0;
                    end else begin
                        waddr_next = waddr_reg + AW'(1);
                    end
                end
            end
            S_FIT: begin
                // Pipelined scan: issue read at ptr, evaluate data of ptr-1.
                if (pend_reg) begin
                    if (rd_used) begin
                        cnt_next = '0;
                    end else begin
                        cnt_next = cnt_reg + 11'd1;
                        if (cnt_reg + 11'd1 == n_reg) begin
                            pos_next = AW'(CW'(cur) + CW'(1) - CW'(n_reg));
                            run_next = CW'(n_reg);
                            waddr_next = AW'(CW'(cur) + CW'(1) - CW'(n_reg));
                            state_next = S_ALLOC;
                        end
                    end
                end
                if (state_next == S_FIT) begin
                    if (ptr_reg < hi_reg) begin
                        ctl.rd_en = 1'b1; ptr_next = ptr_reg + CW'(1); pend_next = 1'b1;
                    end else if (!pend_reg) begin
                        if (second_reg) begin
                            st_next = pfa_pkg::ST_NO_SPACE; state_next = S_DONE;
                        end else begin
                            ptr_next = lo_reg; best_ok_next = 1'b0; state_next = S_OLD;
                        end
                    end
                end
            end
            S_OLD: begin
                if (pend_reg && rd_used && rd_len != '0 && rd_age != '0 &&
                    (!best_ok_reg || rd_age < best_age_reg)) begin
                    best_ok_next = 1'b1; best_next = cur; best_age_next = rd_age;
                end
                if (ptr_reg < hi_reg) begin
                    ctl.rd_en = 1'b1; ptr_next = ptr_reg + CW'(1); pend_next = 1'b1;
                end else if (!pend_reg) begin
                    if (!best_ok_reg) begin
                        st_next = pfa_pkg::ST_NO_SPACE; state_next = S_DONE;
                    end else begin
                        ctl.rd_en = 1'b1; raddr = CW'(best_reg);
                        pos_next = best_reg; state_next = S_FREE;
                        ev_next = 1'b1; evi_next = 10'(best_reg);
                        // Length is taken from the head read in S_FREEW.
                        tgt_alloc_next = 1'b1;
                    end
                end
            end
            S_ALLOC: begin
                ctl.wr_en = 1'b1; ctl.wr_used = 1'b1; wr_age = stamp;
                ctl.wr_len = (run_reg == CW'(n_reg)) ? n_reg : '0;
                run_next = run_reg - CW'(1);
                waddr_next = waddr_reg + AW'(1);
                if (run_reg == CW'(1)) begin
                    age_next = stamp; used_next = used_reg + n_reg;
                    start_next = 10'(pos_reg); state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!out_v_reg) begin
                    out_v_next = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        // An eviction reaches S_FREEW with the victim head on the read port.
        if (state_reg == S_FREEW && tgt_alloc_reg && rd_used && rd_len != '0) begin
            tgt_alloc_next = 1'b1; evl_next = rd_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR; waddr_reg <= '0; out_v_reg <= 1'b0; pend_reg <= 1'b0;
            used_reg <= '0; age_reg <= '0; tgt_alloc_reg <= 1'b0;
        end else begin
            state_reg <= state_next; waddr_reg <= waddr_next; out_v_reg <= out_v_next;
            pend_reg <= pend_next; used_reg <= used_next; age_reg <= age_next;
            tgt_alloc_reg <= tgt_alloc_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next; lo_reg <= lo_next; hi_reg <= hi_next; cnt_reg <= cnt_next;
        n_reg <= n_next; second_reg <= second_next; best_ok_reg <= best_ok_next;
        best_reg <= best_next; best_age_reg <= best_age_next; run_reg <= run_next;
        pos_reg <= pos_next; st_reg <= st_next; start_reg <= start_next;
        ev_reg <= ev_next; evi_reg <= evi_next; evl_reg <= evl_next;
    end
endmodule
`default_nettype wire

>>> hdl/page_frame_allocator_lru_evict.sv
// A free reads the run head and clears the run; an allocate uses first-fit and oldest-run
// scans through the single read port, then writes the run.
// Throughput: one transaction at a time, next accepted after the result is taken.
// Reset: synchronous, active low; a clearing pass that writes every table entry
// runs after reset, during which no transaction is accepted.
// Top level of the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_allocator_lru_evict_assert.svh"
module page_frame_allocator_lru_evict #(
    parameter int PAGE_FRAMES = pfa_pkg::PAGE_FRAMES_DEF,
    parameter int AGE_BITS    = pfa_pkg::AGE_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // op[0], page_count[11:1], page_index[21:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // status[1:0], start_index[11:2], evicted[12],
                                        // evicted_index[22:13], evicted_length[33:23]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data
);
    localparam int AW = $clog2(PAGE_FRAMES);

    logic [9:0]          first_reg;
    logic [10:0]         total_reg;
    pfa_pkg::mem_ctl_t   ctl;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [AGE_BITS-1:0] wr_age, rd_age;
    logic                rd_used;
    logic [10:0]         rd_len;
    logic [1:0]          status;
    logic [9:0]          start, ev_index;
    logic                ev;
    logic [10:0]         ev_len;

    assign cfg_ready = 1'b1;

    // Hold configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= '0; total_reg <= 11'd1024;
        end else if (cfg_valid) begin
            if (cfg_index == pfa_pkg::CFG_FIRST) first_reg <= cfg_data[9:0];
            else total_reg <= cfg_data;
        end
    end

    pfa_ctrl #(.PAGE_FRAMES(PAGE_FRAMES), .AGE_BITS(AGE_BITS)) u_ctrl (
        .aclk, .aresetn,
        .req_valid(s_tvalid), .req_ready(s_tready),
        .req_op(s_tdata[0]), .req_count(s_tdata[11:1]), .req_index(s_tdata[21:12]),
        .first_page(first_reg), .total_pages(total_reg),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_status(status), .res_start(start), .res_evicted(ev),
        .res_ev_index(ev_index), .res_ev_length(ev_len),
        .ctl, .rd_addr, .wr_addr, .wr_age, .rd_used, .rd_len, .rd_age
    );

    pfa_table #(.PAGE_FRAMES(PAGE_FRAMES), .AGE_BITS(AGE_BITS)) u_table (
        .aclk, .ctl, .rd_addr, .wr_addr, .wr_age, .rd_used, .rd_len, .rd_age
    );

    assign m_tdata = {6'd0, ev_len, ev_index, ev, start, status};

    `PFA_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_tvalid, !s_tready, "accept while result pending")
    `PFA_ASSERT_IMP(a_ok_no_evict_len, aclk, aresetn, m_tvalid && !ev, ev_len == 11'd0 && ev_index == 10'd0, "evict fields without eviction")
    `PFA_ASSERT_NXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second accept")
endmodule
`default_nettype wire
